@@ design/dspid_pkg.sv @@
package dspid_pkg;

	localparam int GAIN_W      = 16;
	localparam int SUM_W       = 32;
	localparam int DRIVE_W     = 8;
	localparam int DRIVE_LIMIT = 100;
	localparam int CFG_IDX_W   = 3;
	// left drive, right drive, left active, right active, done, padded to bytes
	localparam int OUT_DATA_W  = ((2 * DRIVE_W + 3 + 7) / 8) * 8;

	localparam logic [GAIN_W-1:0] GAIN_P_RST   = 16'd205;
	localparam logic [GAIN_W-1:0] GAIN_D_RST   = 16'd49;
	localparam logic [GAIN_W-1:0] GAIN_I_RST   = 16'd1024;
	localparam logic [GAIN_W-1:0] STOP_THR_RST = 16'd10;
	localparam logic [GAIN_W-1:0] INT_WIN_RST  = 16'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P    = 3'd0,
		CFG_GAIN_D    = 3'd1,
		CFG_GAIN_I    = 3'd2,
		CFG_STOP_THR  = 3'd3,
		CFG_INT_WIN   = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		ACT_START  = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_d;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] stop_threshold;
		logic [GAIN_W-1:0] integrate_window;
	} cfg_regs_t;

	typedef struct packed {
		logic update;
		logic start;
	} side_ctl_t;

endpackage

@@ design/dspid_side.sv @@
module dspid_side #(
	parameter int POS_WIDTH = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dspid_pkg::side_ctl_t            ctl,
	input  dspid_pkg::cfg_regs_t            cfg,
	input  logic signed [POS_WIDTH-1:0]     target,
	input  logic signed [POS_WIDTH-1:0]     position,
	output logic signed [POS_WIDTH:0]       error,
	output logic signed [POS_WIDTH:0]       prev_error,
	output logic signed [dspid_pkg::SUM_W-1:0] error_sum,
	output logic                            active
);
	import dspid_pkg::*;

	localparam int ERR_W = POS_WIDTH + 1;
	localparam int CMP_W = (ERR_W > GAIN_W) ? ERR_W : GAIN_W;
	localparam int ADD_W = ((ERR_W > SUM_W) ? ERR_W : SUM_W) + 1;
	localparam logic signed [ADD_W-1:0] SAT_HI = ADD_W'({1'b0, {(SUM_W-1){1'b1}}});
	localparam logic signed [ADD_W-1:0] SAT_LO = -SAT_HI - ADD_W'(1);

	logic signed [ERR_W-1:0] error_q, prev_error_q, err_new;
	logic signed [SUM_W-1:0] error_sum_q, sum_sat;
	logic signed [ADD_W-1:0] sum_ext;
	logic [ERR_W-1:0]        err_mag, old_mag;
	logic                    active_q, in_window, active_new;

	always_comb begin
		err_new = ERR_W'(target) - ERR_W'(position);
		err_mag = err_new[ERR_W-1] ? ERR_W'(-err_new) : ERR_W'(err_new);
		// old error becomes prev_error on this sample
		old_mag = error_q[ERR_W-1] ? ERR_W'(-error_q) : ERR_W'(error_q);
		in_window = CMP_W'(err_mag) < CMP_W'(cfg.integrate_window);
		active_new = (CMP_W'(err_mag) > CMP_W'(cfg.stop_threshold)) ||
			(CMP_W'(old_mag) > CMP_W'(cfg.stop_threshold));
		sum_ext = ADD_W'(error_sum_q) + ADD_W'(err_new);
		if (sum_ext > SAT_HI) begin
			sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
		end else if (sum_ext < SAT_LO) begin
			sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_q      <= '0;
			prev_error_q <= '0;
			error_sum_q  <= '0;
			active_q     <= 1'b0;
		end else if (ctl.update) begin
			if (ctl.start) begin
				error_q      <= ERR_W'(target);
				prev_error_q <= ERR_W'(target);
				error_sum_q  <= '0;
				active_q     <= 1'b1;
			end else begin
				prev_error_q <= error_q;
				error_q      <= err_new;
				if (in_window) begin
					error_sum_q <= sum_sat;
				end
				active_q <= active_new;
			end
		end
	end

	assign error      = error_q;
	assign prev_error = prev_error_q;
	assign error_sum  = error_sum_q;
	assign active     = active_q;

endmodule

@@ design/dspid_drive.sv @@
module dspid_drive #(
	parameter int POS_WIDTH      = 20,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  dspid_pkg::cfg_regs_t                 cfg,
	input  logic signed [POS_WIDTH:0]            error,
	input  logic signed [POS_WIDTH:0]            prev_error,
	input  logic signed [dspid_pkg::SUM_W-1:0]   error_sum,
	input  logic                                 active,
	output logic signed [dspid_pkg::DRIVE_W-1:0] drive
);
	import dspid_pkg::*;

	localparam int ERR_W = POS_WIDTH + 1;
	localparam int DIF_W = ERR_W + 1;
	localparam int PP_W  = GAIN_W + 1 + ERR_W;
	localparam int PD_W  = GAIN_W + 1 + DIF_W;
	localparam int PI_W  = GAIN_W + 1 + SUM_W;
	localparam int ACC_W = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
	localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(DRIVE_LIMIT);
	localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI;

	logic signed [DIF_W-1:0] diff;
	logic signed [PP_W-1:0]  prod_p, term_p;
	logic signed [PD_W-1:0]  prod_d, term_d;
	logic signed [PI_W-1:0]  prod_i, term_i;
	logic signed [ACC_W-1:0] acc;

	always_comb begin
		diff   = DIF_W'(prev_error) - DIF_W'(error);
		prod_p = PP_W'($signed({1'b0, cfg.gain_p})) * PP_W'(error);
		prod_d = PD_W'($signed({1'b0, cfg.gain_d})) * PD_W'(diff);
		prod_i = PI_W'($signed({1'b0, cfg.gain_i})) * PI_W'(error_sum);
		// shift toward zero: bias negative products before the arithmetic shift
		term_p = prod_p[PP_W-1]
			? (prod_p + $signed({{(PP_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}}))
				>>> GAIN_FRAC_BITS
			: prod_p >>> GAIN_FRAC_BITS;
		term_d = prod_d[PD_W-1]
			? (prod_d + $signed({{(PD_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}}))
				>>> GAIN_FRAC_BITS
			: prod_d >>> GAIN_FRAC_BITS;
		term_i = prod_i[PI_W-1]
			? (prod_i + $signed({{(PI_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}}))
				>>> GAIN_FRAC_BITS
			: prod_i >>> GAIN_FRAC_BITS;
		acc = ACC_W'(term_p) + ACC_W'(term_d) + ACC_W'(term_i);
		if (!active) begin
			drive = '0;
		end else if (acc > LIM_HI) begin
			drive = DRIVE_W'(DRIVE_LIMIT);
		end else if (acc < LIM_LO) begin
			drive = -DRIVE_W'(DRIVE_LIMIT);
		end else begin
			drive = acc[DRIVE_W-1:0];
		end
	end

endmodule

@@ design/dual_side_position_pid_unit.sv @@
// m_tvalid rises once an accepted input beat has passed the input register,
// then the state update, then the drive/result register.
// Throughput: one item per cycle; each stage holds only while the one after it is full.
// arst_n clears all valids, the move target, both sides' errors and integrals
// (sides inactive) and loads the default gains, threshold and window.
module dual_side_position_pid_unit #(
	parameter int POS_WIDTH      = 20,
	parameter int GAIN_FRAC_BITS = 12,
	localparam int IN_DATA_W     = ((3 * POS_WIDTH + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// target_counts, left_position, right_position
	input  logic [IN_DATA_W-1:0]                s_tdata,
	// action
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// left_drive, right_drive, left_active, right_active, done_res
	output logic [dspid_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dspid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dspid_pkg::GAIN_W-1:0]        cfg_data
);
	import dspid_pkg::*;

	localparam int ERR_W = POS_WIDTH + 1;

	cfg_regs_t cfg_q;

	logic                        valid_s1, valid_s2, out_valid_q;
	action_t                     action_s1;
	logic signed [POS_WIDTH-1:0] target_s1, lpos_s1, rpos_s1, target_q, side_target;
	logic [OUT_DATA_W-1:0]       out_data_q;
	logic                        out_adv, s2_free, s1_adv, s1_free;
	side_ctl_t                   side_ctl;

	logic signed [ERR_W-1:0]   l_err, l_prev, r_err, r_prev;
	logic signed [SUM_W-1:0]   l_sum, r_sum;
	logic                      l_act, r_act;
	logic signed [DRIVE_W-1:0] l_drive, r_drive;

	// config writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p           <= GAIN_P_RST;
			cfg_q.gain_d           <= GAIN_D_RST;
			cfg_q.gain_i           <= GAIN_I_RST;
			cfg_q.stop_threshold   <= STOP_THR_RST;
			cfg_q.integrate_window <= INT_WIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GAIN_P:   cfg_q.gain_p           <= cfg_data;
				CFG_GAIN_D:   cfg_q.gain_d           <= cfg_data;
				CFG_GAIN_I:   cfg_q.gain_i           <= cfg_data;
				CFG_STOP_THR: cfg_q.stop_threshold   <= cfg_data;
				CFG_INT_WIN:  cfg_q.integrate_window <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow
	assign out_adv  = !out_valid_q || m_tready;
	assign s2_free  = !valid_s2 || out_adv;
	assign s1_adv   = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign s_tready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= s_tvalid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_adv) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && s_tvalid) begin
			action_s1 <= action_t'(s_tuser);
			target_s1 <= s_tdata[POS_WIDTH-1:0];
			lpos_s1   <= s_tdata[2*POS_WIDTH-1:POS_WIDTH];
			rpos_s1   <= s_tdata[3*POS_WIDTH-1:2*POS_WIDTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (s1_adv && action_s1 == ACT_START) begin
			target_q <= target_s1;
		end
	end

	// side state regs act as stage 2: they only change when a new beat enters it
	assign side_ctl.update = s1_adv;
	assign side_ctl.start  = (action_s1 == ACT_START);
	assign side_target     = (action_s1 == ACT_START) ? target_s1 : target_q;

	dspid_side #(.POS_WIDTH(POS_WIDTH)) u_side_l (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (side_ctl),
		.cfg        (cfg_q),
		.target     (side_target),
		.position   (lpos_s1),
		.error      (l_err),
		.prev_error (l_prev),
		.error_sum  (l_sum),
		.active     (l_act)
	);

	dspid_side #(.POS_WIDTH(POS_WIDTH)) u_side_r (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (side_ctl),
		.cfg        (cfg_q),
		.target     (side_target),
		.position   (rpos_s1),
		.error      (r_err),
		.prev_error (r_prev),
		.error_sum  (r_sum),
		.active     (r_act)
	);

	dspid_drive #(.POS_WIDTH(POS_WIDTH), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_drive_l (
		.cfg        (cfg_q),
		.error      (l_err),
		.prev_error (l_prev),
		.error_sum  (l_sum),
		.active     (l_act),
		.drive      (l_drive)
	);

	dspid_drive #(.POS_WIDTH(POS_WIDTH), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_drive_r (
		.cfg        (cfg_q),
		.error      (r_err),
		.prev_error (r_prev),
		.error_sum  (r_sum),
		.active     (r_act),
		.drive      (r_drive)
	);

	always_ff @(posedge clk) begin
		if (out_adv) begin
			out_data_q <= {{(OUT_DATA_W-2*DRIVE_W-3){1'b0}},
				!l_act && !r_act, r_act, l_act, r_drive, l_drive};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_done_both_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2*DRIVE_W+2] == (!m_tdata[2*DRIVE_W] && !m_tdata[2*DRIVE_W+1])))
		else $error("done beat does not match side activity");

	a_hold_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2*DRIVE_W] |-> m_tdata[DRIVE_W-1:0] == '0)
		else $error("inactive left side drives nonzero");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[DRIVE_W-1:0]) <= DRIVE_W'(DRIVE_LIMIT) &&
			$signed(m_tdata[DRIVE_W-1:0]) >= -DRIVE_W'(DRIVE_LIMIT)))
		else $error("left drive out of range");

	a_start_active: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && action_s1 == ACT_START |=> l_act && r_act && valid_s2)
		else $error("start beat did not activate both sides");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_adv |=> $stable(l_err) && $stable(r_err) && $stable(l_sum))
		else $error("side state changed while stage 2 stalled");

endmodule

@@ tb/dspid_checker.sv @@
module dspid_checker #(
	parameter int POS_WIDTH      = 20,
	parameter int GAIN_FRAC_BITS = 12,
	parameter int IN_DATA_W      = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	// target_counts, left_position, right_position
	input  logic [IN_DATA_W-1:0]                s_tdata,
	// action
	input  logic                                s_tuser,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	// left_drive, right_drive, left_active, right_active, done_res
	input  logic [dspid_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [dspid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dspid_pkg::GAIN_W-1:0]        cfg_data,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  result_count,
	output int                                  done_count,
	output int                                  sat_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import dspid_pkg::*;

	localparam longint SUM_HI = (longint'(1) << (SUM_W - 1)) - 1;
	localparam longint SUM_LO = -(longint'(1) << (SUM_W - 1));

	typedef struct packed {
		logic signed [DRIVE_W-1:0] left_drive;
		logic signed [DRIVE_W-1:0] right_drive;
		logic                      left_active;
		logic                      right_active;
		logic                      done;
	} drive_beat_t;

	drive_beat_t drives_due[$];

	cfg_regs_t                     cfg_q;
	logic signed [POS_WIDTH-1:0]   target_q;
	logic signed [POS_WIDTH:0]     err_q  [2];
	logic signed [POS_WIDTH:0]     prev_q [2];
	logic signed [SUM_W-1:0]       acc_q  [2];
	logic                          act_q  [2];

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// gain is unsigned fixed point; product truncates toward zero
	function automatic longint gain_term(input logic [GAIN_W-1:0] g, input longint x);
		longint p;
		p = longint'(g) * x;
		if (p < 0)
			return -((-p) >>> GAIN_FRAC_BITS);
		return p >>> GAIN_FRAC_BITS;
	endfunction

	function automatic logic signed [DRIVE_W-1:0] side_drive(input int k);
		longint v;
		if (!act_q[k])
			return '0;
		v = gain_term(cfg_q.gain_p, err_q[k])
		  + gain_term(cfg_q.gain_d, longint'(prev_q[k]) - longint'(err_q[k]))
		  + gain_term(cfg_q.gain_i, acc_q[k]);
		if (v > DRIVE_LIMIT)
			v = DRIVE_LIMIT;
		if (v < -DRIVE_LIMIT)
			v = -DRIVE_LIMIT;
		return v[DRIVE_W-1:0];
	endfunction

	task automatic advance_side(input int k, input logic signed [POS_WIDTH-1:0] pos);
		longint e;
		longint s;
		prev_q[k] = err_q[k];
		e = longint'(target_q) - longint'(pos);
		err_q[k] = e[POS_WIDTH:0];
		if (mag(e) < longint'(cfg_q.integrate_window)) begin
			s = longint'(acc_q[k]) + e;
			if (s > SUM_HI)
				s = SUM_HI;
			if (s < SUM_LO)
				s = SUM_LO;
			acc_q[k] = s[SUM_W-1:0];
		end
		act_q[k] = mag(e) > longint'(cfg_q.stop_threshold) ||
		           mag(prev_q[k]) > longint'(cfg_q.stop_threshold);
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_beat_t want;
		drive_beat_t got;
		if (!arst_n) begin
			cfg_q = '{gain_p: GAIN_P_RST, gain_d: GAIN_D_RST, gain_i: GAIN_I_RST,
			          stop_threshold: STOP_THR_RST, integrate_window: INT_WIN_RST};
			target_q = '0;
			for (int k = 0; k < 2; k++) begin
				err_q[k]  = '0;
				prev_q[k] = '0;
				acc_q[k]  = '0;
				act_q[k]  = 1'b0;
			end
			drives_due.delete();
			fail_count   = 0;
			pending      = 0;
			result_count = 0;
			done_count   = 0;
			sat_count    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GAIN_P:   cfg_q.gain_p = cfg_data;
					CFG_GAIN_D:   cfg_q.gain_d = cfg_data;
					CFG_GAIN_I:   cfg_q.gain_i = cfg_data;
					CFG_STOP_THR: cfg_q.stop_threshold = cfg_data;
					CFG_INT_WIN:  cfg_q.integrate_window = cfg_data;
					default: ;
				endcase
			end

			// result side first: an input beat on this edge cannot show up yet
			if (m_tvalid && m_tready) begin
				got.left_drive   = m_tdata[DRIVE_W-1:0];
				got.right_drive  = m_tdata[2*DRIVE_W-1:DRIVE_W];
				got.left_active  = m_tdata[2*DRIVE_W];
				got.right_active = m_tdata[2*DRIVE_W+1];
				got.done         = m_tdata[2*DRIVE_W+2];
				result_count++;
				if (got.done)
					done_count++;
				if (got.left_drive == DRIVE_LIMIT || got.left_drive == -DRIVE_LIMIT ||
				    got.right_drive == DRIVE_LIMIT || got.right_drive == -DRIVE_LIMIT)
					sat_count++;
				if (drives_due.size() == 0) begin
					if (fail_count < 10)
						$display("%t: unexpected drive beat L=%0d R=%0d act=%b%b done=%b",
						         $realtime, got.left_drive, got.right_drive,
						         got.left_active, got.right_active, got.done);
					fail_count++;
				end else begin
					want = drives_due.pop_front();
					if (want != got) begin
						if (fail_count < 10)
							$display({"%t: drive beat %0d mismatch: exp L=%0d R=%0d act=%b%b done=%b,",
							          " got L=%0d R=%0d act=%b%b done=%b"},
							         $realtime, result_count, want.left_drive,
							         want.right_drive, want.left_active, want.right_active,
							         want.done, got.left_drive, got.right_drive,
							         got.left_active, got.right_active, got.done);
						fail_count++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				if (action_t'(s_tuser) == ACT_START) begin
					target_q = s_tdata[POS_WIDTH-1:0];
					for (int k = 0; k < 2; k++) begin
						err_q[k]  = target_q;
						prev_q[k] = target_q;
						acc_q[k]  = '0;
						act_q[k]  = 1'b1;
					end
				end else begin
					advance_side(0, s_tdata[2*POS_WIDTH-1:POS_WIDTH]);
					advance_side(1, s_tdata[3*POS_WIDTH-1:2*POS_WIDTH]);
				end
				want.left_drive   = side_drive(0);
				want.right_drive  = side_drive(1);
				want.left_active  = act_q[0];
				want.right_active = act_q[1];
				want.done         = !act_q[0] && !act_q[1];
				drives_due.push_back(want);
			end

			pending = drives_due.size();
		end
	end

endmodule

@@ tb/tb_dual_side_position_pid_unit.sv @@
module tb_dual_side_position_pid_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import dspid_pkg::*;

	localparam int     POS_W        = 20;
	localparam int     FRAC_W       = 12;
	localparam int     IN_W         = ((3 * POS_W + 7) / 8) * 8;
	localparam longint POS_MAX      = (longint'(1) << (POS_W - 1)) - 1;
	localparam longint POS_MIN      = -(longint'(1) << (POS_W - 1));
	localparam int     ITEMS_TARGET = 1450;
	localparam int     HOLD_CYCLES  = 300;
	// beats at an error of 65534 at the widest window; both integrators build up
	localparam int     WIND_BEATS   = 200;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_W-1:0]        s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [GAIN_W-1:0]      cfg_data  = '0;

	int fail_count;
	int pending;
	int result_count;
	int done_count;
	int sat_count;

	int items_sent  = 0;
	int cfg_writes  = 0;
	bit tx_quiet    = 1'b0;
	bit rx_quiet    = 1'b0;
	bit rx_hold_req = 1'b0;

	dual_side_position_pid_unit #(
		.POS_WIDTH      (POS_W),
		.GAIN_FRAC_BITS (FRAC_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dspid_checker #(
		.POS_WIDTH      (POS_W),
		.GAIN_FRAC_BITS (FRAC_W),
		.IN_DATA_W      (IN_W)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count),
		.done_count   (done_count),
		.sat_count    (sat_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic signed [POS_W-1:0] clip_pos(input longint v);
		if (v > POS_MAX)
			v = POS_MAX;
		if (v < POS_MIN)
			v = POS_MIN;
		return v[POS_W-1:0];
	endfunction

	function automatic logic signed [POS_W-1:0] rand_pos();
		return clip_pos(longint'($urandom_range(0, (1 << POS_W) - 1)) + POS_MIN);
	endfunction

	function automatic longint pick_target();
		case ($urandom_range(0, 9))
			0: return longint'(rand_pos());
			1: return ($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN;
			default: return longint'($urandom_range(0, 8000)) - 4000;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return GAIN_W'($urandom_range(0, 65535));
			default: return GAIN_W'($urandom_range(0, 8191));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_limit(input int typical);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return GAIN_W'($urandom_range(0, 65535));
			default: return GAIN_W'($urandom_range(0, typical));
		endcase
	endfunction

	// all tasks below are entered and left at a falling edge
	task automatic push_item(input action_t act, input logic signed [POS_W-1:0] tgt,
	                         input logic signed [POS_W-1:0] lpos,
	                         input logic signed [POS_W-1:0] rpos);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser  = act;
		s_tdata  = {{(IN_W - 3 * POS_W){1'b0}}, rpos, lpos, tgt};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cfg(input cfg_idx_t idx, input logic [GAIN_W-1:0] val);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_writes++;
	endtask

	task automatic load_config(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] kd,
	                           input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] thr,
	                           input logic [GAIN_W-1:0] win);
		drain();
		write_cfg(CFG_GAIN_P, kp);
		write_cfg(CFG_GAIN_D, kd);
		write_cfg(CFG_GAIN_I, ki);
		write_cfg(CFG_STOP_THR, thr);
		write_cfg(CFG_INT_WIN, win);
	endtask

	// start, then both sides closing in on the target with jitter, some noise
	// beats and the odd stray start mixed in, then a few settled samples
	task automatic run_move(input int steps);
		longint tgt, org_l, org_r, pl, pr;
		int     jit;
		tgt   = pick_target();
		org_l = ($urandom_range(0, 5) == 0) ? longint'(rand_pos())
		                                    : tgt + longint'($urandom_range(0, 6000)) - 3000;
		org_r = ($urandom_range(0, 5) == 0) ? longint'(rand_pos())
		                                    : tgt + longint'($urandom_range(0, 6000)) - 3000;
		jit   = $urandom_range(0, 3);
		push_item(ACT_START, clip_pos(tgt), rand_pos(), rand_pos());
		for (int k = 1; k <= steps; k++) begin
			if ($urandom_range(0, 11) == 0) begin
				push_item(ACT_SAMPLE, rand_pos(), rand_pos(), rand_pos());
			end else if ($urandom_range(0, 29) == 0) begin
				push_item(ACT_START, clip_pos(pick_target()), rand_pos(), rand_pos());
			end else begin
				pl = tgt - ((tgt - org_l) * (steps - k)) / steps
				   + longint'($urandom_range(0, 2 * jit)) - jit;
				pr = tgt - ((tgt - org_r) * (steps - k)) / steps
				   + longint'($urandom_range(0, 2 * jit)) - jit;
				push_item(ACT_SAMPLE, rand_pos(), clip_pos(pl), clip_pos(pr));
			end
		end
		repeat ($urandom_range(1, 4))
			push_item(ACT_SAMPLE, rand_pos(),
			          clip_pos(tgt + longint'($urandom_range(0, 4)) - 2),
			          clip_pos(tgt + longint'($urandom_range(0, 4)) - 2));
	endtask

	// result side: random stall per beat, one long hold-off on request
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = rx_quiet ? 0 : $urandom_range(0, 15);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		int phase_no;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset configuration
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(0), clip_pos(0));
		push_item(ACT_SAMPLE, rand_pos(), clip_pos(POS_MAX), clip_pos(POS_MIN));
		push_item(ACT_START, clip_pos(POS_MAX), clip_pos(0), clip_pos(0));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(POS_MIN), clip_pos(POS_MAX));
		push_item(ACT_START, clip_pos(POS_MIN), clip_pos(POS_MAX), clip_pos(POS_MIN));
		push_item(ACT_SAMPLE, clip_pos(POS_MAX), clip_pos(POS_MAX), clip_pos(POS_MIN));
		push_item(ACT_START, clip_pos(0), clip_pos(-1), clip_pos(-1));
		push_item(ACT_START, clip_pos(1000), clip_pos(0), clip_pos(0));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(300), clip_pos(600));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(700), clip_pos(900));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(950), clip_pos(990));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(995), clip_pos(1003));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(1000), clip_pos(1000));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(1000), clip_pos(1000));
		// move already finished, left side pushed away again
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(600), clip_pos(1000));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(1000), clip_pos(1000));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(1000), clip_pos(1000));
		push_item(ACT_START, clip_pos(-777), clip_pos(0), clip_pos(0));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(-770), clip_pos(-785));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(-775), clip_pos(-779));
		push_item(ACT_SAMPLE, clip_pos(0), clip_pos(-777), clip_pos(-777));

		phase_no = 0;
		while (items_sent < ITEMS_TARGET - WIND_BEATS) begin
			case (phase_no)
				0: load_config('0, '0, '0, '0, '0);
				1: load_config('1, '1, '1, '1, '1);
				2: load_config(GAIN_P_RST, GAIN_D_RST, GAIN_I_RST, STOP_THR_RST, INT_WIN_RST);
				default: load_config(pick_gain(), pick_gain(), pick_gain(),
				                     pick_limit(40), pick_limit(400));
			endcase
			if (phase_no == 3) begin
				// receiver stalls long while the sender keeps pushing
				tx_quiet    = 1'b1;
				rx_quiet    = 1'b0;
				rx_hold_req = 1'b1;
				run_move(40);
			end
			for (int m = 0; m < 8 && items_sent < ITEMS_TARGET - WIND_BEATS; m++) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
				run_move($urandom_range(4, 30));
			end
			phase_no++;
		end

		// integrator build-up in both directions, widest window
		load_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(40), '1);
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		push_item(ACT_START, clip_pos(0), clip_pos(0), clip_pos(0));
		repeat (WIND_BEATS)
			push_item(ACT_SAMPLE, rand_pos(), clip_pos(-65534), clip_pos(65534));
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		drain();
		repeat (10) @(negedge clk);

		$display("Checked %0d drive beats: %0d with the move finished, %0d at the drive limit",
		         result_count, done_count, sat_count);
		$display("Stimulus: %0d input beats over %0d register settings phases, %0d register writes",
		         items_sent, phase_no + 1, cfg_writes);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
design/dspid_pkg.sv
design/dspid_side.sv
design/dspid_drive.sv
design/dual_side_position_pid_unit.sv
tb/dspid_checker.sv
tb/tb_dual_side_position_pid_unit.sv
